@@ src/slin_pkg.sv @@
// Shared types, widths and codes for the sensor table linearizer.
// No dependencies; every other file in src except slin_ram imports this package.
package slin_pkg;

    // Defaults for the top level parameters
    localparam int TABLE_ROWS_DEF = 128;
    localparam int ADC_BITS_DEF   = 10;

    // Field widths
    localparam int LEVEL_W     = 16;
    localparam int DIST_W      = 16;
    localparam int ENTRY_W     = DIST_W + LEVEL_W;
    localparam int ROW_INDEX_W = 7;
    localparam int ROWS_CFG_W  = 8;
    localparam int WEIGHT_W    = 9;
    localparam int STATUS_W    = 2;

    // Filter datapath: w*s + (256-w)*prev + 128 stays below 2^24
    localparam int FILT_W = 25;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

    // Serial divider: quotient never exceeds the distance span
    localparam int QUO_W      = 16;
    localparam int DIVISOR_W  = LEVEL_W + 1;
    localparam int DIVIDEND_W = QUO_W + DIVISOR_W;
    localparam int STEP_CNT_W = $clog2(QUO_W + 1);

    // APB
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes (paddr bit 2)
    localparam logic REG_ROWS   = 1'b0;
    localparam logic REG_WEIGHT = 1'b1;

    // Reset values
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET   = 8'd70;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET = 9'd230;

    // Request codes
    localparam logic REQ_ROW_WRITE = 1'b0;
    localparam logic REQ_SAMPLE    = 1'b1;

    // Range status codes
    localparam logic [STATUS_W-1:0] RANGE_IN_TABLE = 2'd0;
    localparam logic [STATUS_W-1:0] RANGE_ABOVE    = 2'd1;
    localparam logic [STATUS_W-1:0] RANGE_BELOW    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP,
        S_FILT_MUL,
        S_FILT_SUM,
        S_SEARCH,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ src/slin_if.sv @@
// Valid/ready channel interfaces for the request and result words.
// Depends on slin_pkg.
interface slin_req_if
    import slin_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [ROW_INDEX_W-1:0] row_index;
    logic [DIST_W-1:0]      row_distance;
    logic [LEVEL_W-1:0]     row_level;
    logic [ADC_BITS-1:0]    adc_sample;

    modport source (output valid, req_type, row_index, row_distance, row_level, adc_sample,
                    input ready);
    modport sink   (input valid, req_type, row_index, row_distance, row_level, adc_sample,
                    output ready);
endinterface

interface slin_rsp_if
    import slin_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [DIST_W-1:0]   distance;
    logic [LEVEL_W-1:0]  filtered_level;
    logic [STATUS_W-1:0] range_status;

    modport source (output valid, distance, filtered_level, range_status, input ready);
    modport sink   (input valid, distance, filtered_level, range_status, output ready);
endinterface

@@ src/smoothed_sensor_table_linearizer.sv @@
// Top level of the smoothed sensor table linearizer: sequencer, filter, APB registers.
// Depends on slin_pkg, slin_if (slin_req_if, slin_rsp_if), slin_ram and slin_div.
//
// Usage
//   req_ch carries one word per request. req_type = 0 writes calibration row
//   row_index (taken modulo TABLE_ROWS) with row_distance/row_level; no result.
//   req_type = 1 presents adc_sample; the block smooths it, searches the table
//   for the first row whose level is at or below the filtered level, and
//   interpolates the distance between that row and the one before it.
//   rsp_ch returns one word per sample: distance, filtered_level, range_status
//   (in table, clamped above first row, clamped below last row).
//   APB: rows_in_use at 0x0, smoothing_weight at 0x4. Write only while idle.
// Timing
//   One request at a time; req_ch.ready is high while the sequencer is idle.
//   Row write: S_WRAP subtracts TABLE_ROWS from row_index until it fits, then writes the row.
//   Sample: the time is set mostly by the table walk over n = clamped rows_in_use
//   rows (one row per cycle through the single RAM read port) and by the serial
//   divider. Early hits finish sooner.
//   The result sits in an output register; a new request is accepted while it
//   waits, and the sequencer only stalls when a second result is ready
//   before the receiver has taken the first.
// Reset
//   Clears the filter state to 0, rows_in_use to 70, weight to 230. The
//   table is not cleared; rows must be written before samples use them.
module smoothed_sensor_table_linearizer
    import slin_pkg::*;
#(
    parameter int TABLE_ROWS = TABLE_ROWS_DEF,
    parameter int ADC_BITS   = ADC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    slin_req_if.sink              req_ch,
    slin_rsp_if.source            rsp_ch
);

    localparam int IDX_W = $clog2(TABLE_ROWS);
    localparam int CNT_W = $clog2(TABLE_ROWS + 1);

    // Control state
    state_t                state_reg, state_next;
    logic [ROWS_CFG_W-1:0] rows_reg, rows_next;
    logic [WEIGHT_W-1:0]   weight_reg, weight_next;
    logic [LEVEL_W-1:0]    smooth_reg, smooth_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  pend_reg, pend_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;

    // Datapath registers
    logic [ROW_INDEX_W-1:0] wrap_reg, wrap_next;
    logic [DIST_W-1:0]      wr_dist_reg, wr_dist_next;
    logic [LEVEL_W-1:0]     wr_level_reg, wr_level_next;
    logic [ADC_BITS-1:0]    adc_reg, adc_next;
    logic [FILT_W-1:0]      prod_reg, prod_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [LEVEL_W-1:0]     prev_level_reg, prev_level_next;
    logic [DIST_W-1:0]      prev_dist_reg, prev_dist_next;
    logic [LEVEL_W-1:0]     num_reg, num_next;
    logic [LEVEL_W-1:0]     den_reg, den_next;
    logic [DIST_W-1:0]      mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [2*DIST_W-1:0]    mul_reg, mul_next;
    logic [DIST_W-1:0]      res_dist_reg, res_dist_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [DIST_W-1:0]      rsp_dist_reg, rsp_dist_next;
    logic [LEVEL_W-1:0]     rsp_level_reg, rsp_level_next;
    logic [STATUS_W-1:0]    rsp_status_reg, rsp_status_next;

    // Combinational helpers
    logic [31:0]           n_wide;
    logic [CNT_W-1:0]      n_rows;
    logic [WEIGHT_W-1:0]   w_eff;
    logic [LEVEL_W-1:0]    sample_q;
    logic [FILT_W-1:0]     filt_sum;
    logic [LEVEL_W:0]      filt_top;
    logic [LEVEL_W-1:0]    rd_level;
    logic [DIST_W-1:0]     rd_dist;
    logic [QUO_W-1:0]      q_clamped;
    logic                  cfg_write;
    logic                  req_ready;

    // RAM and divider hookup
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    div_stat_t             div_stat;
    logic [QUO_W-1:0]      div_quo;

    // Calibration table: {distance, level} per row
    slin_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ROWS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    slin_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Effective row count and weight
    always_comb
    begin
        n_wide = 32'(rows_reg);
        if (n_wide < 32'd2)
        begin
            n_wide = 32'd2;
        end
        else if (n_wide > 32'(TABLE_ROWS))
        begin
            n_wide = 32'(TABLE_ROWS);
        end
        n_rows = CNT_W'(n_wide);
        w_eff  = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    end

    assign sample_q  = LEVEL_W'(adc_reg) << (LEVEL_W - ADC_BITS);
    // Second filter term plus rounding constant, added to the first product
    assign filt_sum  = prod_reg + FILT_W'(WEIGHT_ONE - w_eff) * FILT_W'(smooth_reg)
                       + FILT_W'(128);
    assign filt_top  = filt_sum[FILT_W-1:8];
    assign rd_level  = ram_rdata[LEVEL_W-1:0];
    assign rd_dist   = ram_rdata[ENTRY_W-1:LEVEL_W];
    assign q_clamped = (div_quo > mag_reg) ? mag_reg : div_quo;

    assign div_dividend = {1'b0, mul_reg} + DIVIDEND_W'({den_reg, 1'b0})
                          - DIVIDEND_W'(den_reg) + DIVIDEND_W'(mul_reg);
    assign div_divisor  = {den_reg, 1'b0};

    assign cfg_write = psel && penable && pwrite;

    // Sequencer and next-state logic
    always_comb
    begin
        state_next      = state_reg;
        rows_next       = rows_reg;
        weight_next     = weight_reg;
        smooth_next     = smooth_reg;
        pend_next       = pend_reg;
        rd_idx_next     = rd_idx_reg;
        wrap_next       = wrap_reg;
        wr_dist_next    = wr_dist_reg;
        wr_level_next   = wr_level_reg;
        adc_next        = adc_reg;
        prod_next       = prod_reg;
        cmp_idx_next    = cmp_idx_reg;
        prev_level_next = prev_level_reg;
        prev_dist_next  = prev_dist_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        mul_next        = mul_reg;
        res_dist_next   = res_dist_reg;
        res_status_next = res_status_reg;
        rsp_dist_next   = rsp_dist_reg;
        rsp_level_next  = rsp_level_reg;
        rsp_status_next = rsp_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ch.ready;
        ram_we          = 1'b0;
        ram_waddr       = IDX_W'(wrap_reg);
        ram_wdata       = {wr_dist_reg, wr_level_reg};
        ram_re          = 1'b0;
        ram_raddr       = rd_idx_reg[IDX_W-1:0];
        div_start       = 1'b0;
        req_ready       = 1'b0;

        if (cfg_write)
        begin
            case (paddr[APB_ADDR_W-1])
                REG_ROWS:   rows_next   = pwdata[ROWS_CFG_W-1:0];
                REG_WEIGHT: weight_next = pwdata[WEIGHT_W-1:0];
                default:    rows_next   = rows_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_ch.valid)
                begin
                    if (req_ch.req_type == REQ_ROW_WRITE)
                    begin
                        wrap_next     = req_ch.row_index;
                        wr_dist_next  = req_ch.row_distance;
                        wr_level_next = req_ch.row_level;
                        state_next    = S_WRAP;
                    end
                    else
                    begin
                        adc_next   = req_ch.adc_sample;
                        state_next = S_FILT_MUL;
                    end
                end
            end

            S_WRAP:
            begin
                // fold the row index into the table, one subtract per cycle
                if (32'(wrap_reg) >= 32'(TABLE_ROWS))
                begin
                    wrap_next = wrap_reg - ROW_INDEX_W'(TABLE_ROWS);
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_FILT_MUL:
            begin
                prod_next  = FILT_W'(w_eff) * FILT_W'(sample_q);
                state_next = S_FILT_SUM;
            end

            S_FILT_SUM:
            begin
                smooth_next = filt_top[LEVEL_W] ? {LEVEL_W{1'b1}} : filt_top[LEVEL_W-1:0];
                rd_idx_next = '0;
                pend_next   = 1'b0;
                state_next  = S_SEARCH;
            end

            S_SEARCH:
            begin
                // read row rd_idx while comparing the row read last cycle
                if (rd_idx_reg < n_rows)
                begin
                    ram_re       = 1'b1;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (rd_level <= smooth_reg)
                    begin
                        pend_next = 1'b0;
                        if (cmp_idx_reg == '0)
                        begin
                            res_dist_next   = rd_dist;
                            res_status_next = RANGE_ABOVE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            res_status_next = RANGE_IN_TABLE;
                            num_next        = prev_level_reg - smooth_reg;
                            den_next        = prev_level_reg - rd_level;
                            neg_next        = rd_dist < prev_dist_reg;
                            mag_next        = (rd_dist >= prev_dist_reg) ?
                                              rd_dist - prev_dist_reg :
                                              prev_dist_reg - rd_dist;
                            if (prev_level_reg <= rd_level)
                            begin
                                // zero interval guard
                                res_dist_next = prev_dist_reg;
                                state_next    = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                    end
                    else
                    begin
                        prev_level_next = rd_level;
                        prev_dist_next  = rd_dist;
                        if (CNT_W'(cmp_idx_reg) == n_rows - CNT_W'(1))
                        begin
                            pend_next       = 1'b0;
                            res_dist_next   = rd_dist;
                            res_status_next = RANGE_BELOW;
                            state_next      = S_DONE;
                        end
                    end
                end
            end

            S_MUL:
            begin
                mul_next   = (2*DIST_W)'(num_reg) * (2*DIST_W)'(mag_reg);
                state_next = S_DIV_START;
            end

            S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    res_dist_next = neg_reg ? prev_dist_reg - q_clamped
                                            : prev_dist_reg + q_clamped;
                    state_next    = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ch.ready)
                begin
                    rsp_dist_next   = res_dist_reg;
                    rsp_level_next  = smooth_reg;
                    rsp_status_next = res_status_reg;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_reg      <= ROWS_RESET;
            weight_reg    <= WEIGHT_RESET;
            smooth_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            weight_reg    <= weight_next;
            smooth_reg    <= smooth_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_reg      <= pend_next;
            rd_idx_reg    <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wrap_reg       <= wrap_next;
        wr_dist_reg    <= wr_dist_next;
        wr_level_reg   <= wr_level_next;
        adc_reg        <= adc_next;
        prod_reg       <= prod_next;
        cmp_idx_reg    <= cmp_idx_next;
        prev_level_reg <= prev_level_next;
        prev_dist_reg  <= prev_dist_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        mul_reg        <= mul_next;
        res_dist_reg   <= res_dist_next;
        res_status_reg <= res_status_next;
        rsp_dist_reg   <= rsp_dist_next;
        rsp_level_reg  <= rsp_level_next;
        rsp_status_reg <= rsp_status_next;
    end

    // APB read side
    always_comb
    begin
        case (paddr[APB_ADDR_W-1])
            REG_ROWS:   prdata = APB_DATA_W'(rows_reg);
            REG_WEIGHT: prdata = APB_DATA_W'(weight_reg);
            default:    prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Channel outputs
    assign req_ch.ready          = req_ready;
    assign rsp_ch.valid          = rsp_valid_reg;
    assign rsp_ch.distance       = rsp_dist_reg;
    assign rsp_ch.filtered_level = rsp_level_reg;
    assign rsp_ch.range_status   = rsp_status_reg;

    // Checks
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the done state");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> rd_idx_reg <= n_rows)
        else $error("table walk ran past the row count");

    a_filter_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(smooth_reg) |-> $past(state_reg) == S_FILT_SUM)
        else $error("filter state changed outside a sample");

endmodule

@@ src/slin_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
module slin_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/slin_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on slin_pkg. Caller guarantees dividend < divisor * 2^QUO_W.
module slin_div
    import slin_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output div_stat_t             stat,
    output logic [QUO_W-1:0]      quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]      quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg)
        begin
            rem_next  = dividend[DIVIDEND_W-1:QUO_W];
            quo_next  = dividend[QUO_W-1:0];
            dvs_next  = divisor;
            cnt_next  = STEP_CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift next dividend bit into the remainder, shift quotient bit into quo_reg
            quo_next = {quo_reg[QUO_W-2:0], fits};
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - STEP_CNT_W'(1);
            if (cnt_reg == STEP_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for smoothed_sensor_table_linearizer: APB register setup,
// calibration row writes and ADC samples, each result checked against a local predictor.
// Depends on slin_pkg, slin_if and the RTL under src.
module tb;
    import slin_pkg::*;

    // Margin after a drain so any trailing request finishes before APB writes.
    localparam int LAT_CYCLES     = 200;
    // Cycles with no handshake on any port before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TBL_ROWS       = TABLE_ROWS_DEF;
    localparam int ADC_W          = ADC_BITS_DEF;

    typedef struct packed {
        logic [DIST_W-1:0]   distance;
        logic [LEVEL_W-1:0]  filtered_level;
        logic [STATUS_W-1:0] range_status;
    } reading_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    slin_req_if #(.ADC_BITS(ADC_W)) req_ch ();
    slin_rsp_if                     rsp_ch ();

    smoothed_sensor_table_linearizer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req_ch  (req_ch),
        .rsp_ch  (rsp_ch)
    );

    always #4 clk = ~clk;

    // Predictor state: mirror of the block's registers, filter and calibration table.
    logic [ROWS_CFG_W-1:0] rows_cfg;
    logic [WEIGHT_W-1:0]   weight_cfg;
    logic [LEVEL_W-1:0]    filt_state;
    logic [LEVEL_W-1:0]    level_tab [TBL_ROWS];
    logic [DIST_W-1:0]     dist_tab  [TBL_ROWS];

    reading_t pending_readings [$];   // expected result words, oldest first
    int       err_count = 0;          // result checker
    int       reg_err_count = 0;      // register readback
    int       send_idle_pct;
    int       recv_idle_pct;
    int       quiet_cycles = 0;

    // Smooth the sample, walk the table, interpolate. Updates the filter state.
    function automatic reading_t predict_reading(input logic [ADC_W-1:0] adc);
        int unsigned     w, s, f, n, hit;
        longint unsigned lo, hi, d0, d1, num, den, mag, q, dist_out;
        reading_t        r;
        w = (weight_cfg > WEIGHT_ONE) ? 256 : 32'(weight_cfg);
        s = 32'(adc);
        s = s << (LEVEL_W - ADC_W);
        f = (w * s + (256 - w) * 32'(filt_state) + 128) >> 8;
        if (f > 65535)
            f = 65535;
        filt_state = f[LEVEL_W-1:0];

        n = 32'(rows_cfg);
        if (n < 2)
            n = 2;
        if (n > TBL_ROWS)
            n = TBL_ROWS;

        // first row whose level is at or below the filtered level
        hit = n;
        for (int k = 0; k < n; k++)
            if (32'(level_tab[k]) <= f && hit == n)
                hit = k;

        r.filtered_level = f[LEVEL_W-1:0];
        r.range_status   = RANGE_IN_TABLE;
        if (hit == 0) begin
            r.distance     = dist_tab[0];
            r.range_status = RANGE_ABOVE;
        end
        else if (hit == n) begin
            r.distance     = dist_tab[n-1];
            r.range_status = RANGE_BELOW;
        end
        else begin
            lo = 64'(level_tab[hit-1]);
            hi = 64'(level_tab[hit]);
            d0 = 64'(dist_tab[hit-1]);
            d1 = 64'(dist_tab[hit]);
            if (lo <= hi) begin
                // flat interval: hold the lower row
                r.distance = d0[DIST_W-1:0];
            end
            else begin
                den = lo - hi;
                num = lo - 64'(f);
                mag = (d1 >= d0) ? d1 - d0 : d0 - d1;
                // round to nearest, halves away from zero in magnitude
                q = (2 * num * mag + den) / (2 * den);
                if (q > mag)
                    q = mag;
                dist_out   = (d1 >= d0) ? d0 + q : d0 - q;
                r.distance = dist_out[DIST_W-1:0];
            end
        end
        return r;
    endfunction

    // One request word. Valid stays high after acceptance; the next call either
    // replaces the payload or drops valid for an idle gap.
    task automatic send_word(input logic kind, input logic [ROW_INDEX_W-1:0] idx,
                             input logic [DIST_W-1:0] rdist, input logic [LEVEL_W-1:0] rlev,
                             input logic [ADC_W-1:0] adc);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.row_index    <= idx;
        req_ch.row_distance <= rdist;
        req_ch.row_level    <= rlev;
        req_ch.adc_sample   <= adc;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (kind == REQ_SAMPLE) begin
            pending_readings.push_back(predict_reading(adc));
        end
        else begin
            level_tab[idx % TBL_ROWS] = rlev;
            dist_tab[idx % TBL_ROWS]  = rdist;
        end
    endtask

    // Unused fields carry random bits so the block is seen to ignore them.
    task automatic write_row(input int unsigned idx, input int unsigned rdist,
                             input int unsigned rlev);
        send_word(REQ_ROW_WRITE, idx[ROW_INDEX_W-1:0], rdist[DIST_W-1:0], rlev[LEVEL_W-1:0],
                  ADC_W'($urandom_range(0, (1 << ADC_W) - 1)));
    endtask

    task automatic take_sample(input int unsigned adc);
        send_word(REQ_SAMPLE, ROW_INDEX_W'($urandom_range(0, TBL_ROWS - 1)),
                  DIST_W'($urandom_range(0, 65535)), LEVEL_W'($urandom_range(0, 65535)),
                  adc[ADC_W-1:0]);
    endtask

    // Stop sending and wait for every outstanding result word.
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Setup + access phase, then an idle gap with psel low, so back-to-back calls
    // never lower and raise psel in the same step.
    task automatic apb_transfer(input logic is_write, input logic reg_idx,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic reg_idx);
        logic [APB_DATA_W-1:0] rd, want, mask;
        mask = (reg_idx == REG_ROWS) ? APB_DATA_W'({ROWS_CFG_W{1'b1}})
                                     : APB_DATA_W'({WEIGHT_W{1'b1}});
        want = (reg_idx == REG_ROWS) ? APB_DATA_W'(rows_cfg) : APB_DATA_W'(weight_cfg);
        apb_transfer(1'b0, reg_idx, '0, rd);
        if ((rd & mask) != want) begin
            $display("%0t ERROR register %0d readback: expected %h actual %h",
                     $time, reg_idx, want, rd & mask);
            reg_err_count++;
        end
    endtask

    // Registers change only with the block idle: drain, then let any trailing
    // row write finish.
    task automatic set_reg(input logic reg_idx, input int unsigned value);
        logic [APB_DATA_W-1:0] rd;
        hold_until_drained();
        repeat (LAT_CYCLES) @(posedge clk);
        apb_transfer(1'b1, reg_idx, value, rd);
        if (reg_idx == REG_ROWS)
            rows_cfg = value[ROWS_CFG_W-1:0];
        else
            weight_cfg = value[WEIGHT_W-1:0];
        check_reg(reg_idx);
    endtask

    // Strictly falling levels over rows 0..n_rows-1, random distances.
    task automatic write_falling_rows(input int unsigned n_rows);
        int unsigned top, step, lev;
        top  = $urandom_range(32768, 65535);
        step = top / n_rows;
        for (int k = 0; k < n_rows; k++) begin
            lev = top - k * step - ((step > 1) ? $urandom_range(0, step - 1) : 0);
            write_row(k, $urandom_range(0, 65535), lev);
        end
    endtask

    task automatic test_register_reset();
        check_reg(REG_ROWS);
        check_reg(REG_WEIGHT);
    endtask

    // Extremes of distance, level and ADC code, both request kinds, all three range outcomes,
    // rounding halves both ways, weight and row-count clamps, equal levels.
    task automatic test_directed_corners();
        set_reg(REG_ROWS, 2);
        set_reg(REG_WEIGHT, 256);
        write_row(0, 16'h0000, 16'hFFFF);
        write_row(1, 16'hFFFF, 16'h0000);
        take_sample(0);                       // bottom of span, full distance
        take_sample(1023);                    // top code
        take_sample(10'h200);
        write_row(0, 16'hFFFF, 16'h8000);     // distance falls with row
        write_row(1, 16'h0000, 16'h4000);
        take_sample(10'h300);                 // above first row
        take_sample(10'h180);                 // inside, negative slope
        take_sample(0);                       // below last row
        write_row(0, 16'h0100, 16'h0080);
        write_row(1, 16'h0101, 16'h0000);
        take_sample(1);                       // exact half, rounds up
        write_row(1, 16'h00FF, 16'h0000);
        take_sample(1);                       // exact half, rounds down in value
        set_reg(REG_WEIGHT, 0);               // filter frozen
        take_sample(1023);
        set_reg(REG_WEIGHT, 511);             // counts as full weight
        take_sample(1023);
        set_reg(REG_WEIGHT, 128);
        take_sample(0);
        take_sample(10'h155);
        take_sample(10'h2AA);
        set_reg(REG_ROWS, 0);                 // counts as two rows
        take_sample(0);
        set_reg(REG_ROWS, 1);
        write_row(0, 16'h1234, 16'h0040);     // equal levels in adjacent rows
        write_row(1, 16'h4321, 16'h0040);
        take_sample(1023);
        take_sample(0);
    endtask

    // Every row written once, so any row count is safe from here on.
    task automatic test_table_fill();
        write_falling_rows(TBL_ROWS);
    endtask

    // One round of random traffic at one setting: mostly samples, against falling rows
    // written afresh when at most 40 rows are in use; some stray row writes with random content.
    task automatic test_traffic_round(input int send_pct, input int recv_pct,
                                      input int unsigned rows_val, input int unsigned weight_val,
                                      input int n_items);
        int unsigned n_eff, pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_reg(REG_ROWS, rows_val);
        set_reg(REG_WEIGHT, weight_val);
        n_eff = (rows_val < 2) ? 2 : ((rows_val > TBL_ROWS) ? TBL_ROWS : rows_val);
        if (n_eff <= 40)
            write_falling_rows(n_eff);
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2)
                hold_until_drained();         // sender waits for a full drain
            pick = $urandom_range(0, 99);
            if (pick < 80)
                take_sample($urandom_range(0, 1023));
            else if (pick < 85)
                take_sample($urandom_range(0, 1) ? 1023 : 0);
            else
                write_row($urandom_range(0, TBL_ROWS - 1), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
        end
    endtask

    // Result side: random backpressure and in-order compare of each word.
    always @(posedge clk) begin
        reading_t want;
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t ERROR unexpected result word: expected none actual %h/%h/%h",
                         $time, rsp_ch.distance, rsp_ch.filtered_level, rsp_ch.range_status);
                err_count++;
            end
            else begin
                want = pending_readings.pop_front();
                if (rsp_ch.distance !== want.distance) begin
                    $display("%0t ERROR distance: expected %h actual %h",
                             $time, want.distance, rsp_ch.distance);
                    err_count++;
                end
                if (rsp_ch.filtered_level !== want.filtered_level) begin
                    $display("%0t ERROR filtered_level: expected %h actual %h",
                             $time, want.filtered_level, rsp_ch.filtered_level);
                    err_count++;
                end
                if (rsp_ch.range_status !== want.range_status) begin
                    $display("%0t ERROR range_status: expected %h actual %h",
                             $time, want.range_status, rsp_ch.range_status);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: any handshake on any port counts as progress.
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_ROW_WRITE;
        req_ch.row_index    = '0;
        req_ch.row_distance = '0;
        req_ch.row_level    = '0;
        req_ch.adc_sample   = '0;
        rows_cfg            = ROWS_RESET;
        weight_cfg          = WEIGHT_RESET;
        filt_state          = '0;
        send_idle_pct       = 21;
        recv_idle_pct       = 80;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_directed_corners();
        test_table_fill();
        test_traffic_round(21, 80, 255, 256, 65);
        test_traffic_round(21, 80, $urandom_range(3, 40), $urandom_range(1, 255), 65);
        test_traffic_round(80, 21, 128, 511, 65);
        test_traffic_round(80, 21, $urandom_range(41, 127), 230, 65);
        test_traffic_round(0, 0, 2, $urandom_range(1, 255), 65);
        test_traffic_round(0, 0, $urandom_range(129, 254), $urandom_range(1, 255), 65);

        hold_until_drained();
        repeat (LAT_CYCLES) @(posedge clk);
        if (err_count + reg_err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
